FILE: hw/rtl/slcp_pkg.sv
// shared constants, types and the crc-8 step for the sync/length/crc8 deframer
`timescale 1ns / 1ps

package slcp_pkg;

	localparam int MAX_PAYLOAD = 252;

	localparam logic [7:0] SYNC_RESET = 8'hAA;
	localparam logic [7:0] CRC_POLY   = 8'h07;

	// parser phases
	localparam logic [1:0] PH_HUNT  = 2'd0;
	localparam logic [1:0] PH_LEN   = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;
	localparam logic [1:0] PH_CHECK = 2'd3;

	// result status codes
	localparam logic [2:0] ST_MORE = 3'd0;
	localparam logic [2:0] ST_DONE = 3'd1;
	localparam logic [2:0] ST_ZERO = 3'd2;
	localparam logic [2:0] ST_LONG = 3'd3;
	localparam logic [2:0] ST_CRC  = 3'd4;

	localparam logic [7:0] LEN_LIMIT = 8'(MAX_PAYLOAD + 1);

	// result of one beat waiting for its store read to come back
	typedef struct packed {
		logic       valid;
		logic [2:0] status;
		logic       hit;
		logic [7:0] cmd;
		logic [7:0] len;
		logic [7:0] rdata;
	} stage_t;

	// msb-first crc-8 over one byte
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: hw/rtl/slcp_parser.sv
// parser state, double-buffered frame store and the store-read stage
`timescale 1ns / 1ps

module slcp_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           sync_value,
	input  logic                 accept,
	input  logic                 advance,
	input  logic                 req_type,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           read_index,
	output slcp_pkg::stage_t     stage
);

	logic [1:0] phase_q;
	logic [7:0] frame_length_q;
	logic [7:0] byte_count_q;
	logic [7:0] crc_q;
	logic       bank_q;
	logic [7:0] pub_cmd_q;
	logic [7:0] pub_len_q;
	logic [7:0] cmd_q;

	logic [7:0] store_mem [512];
	logic [7:0] rd_q;

	logic       valid_s1;
	logic [2:0] status_s1;
	logic       hit_s1;
	logic [7:0] cmd_s1;
	logic [7:0] len_s1;

	logic [1:0] phase_d;
	logic [7:0] frame_length_d;
	logic [7:0] byte_count_d;
	logic [7:0] crc_d;
	logic       bank_d;
	logic [7:0] pub_cmd_d;
	logic [7:0] pub_len_d;
	logic [7:0] cmd_d;
	logic [2:0] status_d;
	logic       wr_en;
	logic [7:0] count_inc;

	assign count_inc = byte_count_q + 8'd1;
	assign wr_en     = accept && !req_type && (phase_q == slcp_pkg::PH_DATA);

	always_comb begin
		phase_d        = phase_q;
		frame_length_d = frame_length_q;
		byte_count_d   = byte_count_q;
		crc_d          = crc_q;
		bank_d         = bank_q;
		pub_cmd_d      = pub_cmd_q;
		pub_len_d      = pub_len_q;
		cmd_d          = cmd_q;
		status_d       = slcp_pkg::ST_MORE;
		if (!req_type) begin
			unique case (phase_q)
				slcp_pkg::PH_HUNT: begin
					if (rx_byte == sync_value) begin
						phase_d        = slcp_pkg::PH_LEN;
						frame_length_d = 8'd0;
						byte_count_d   = 8'd0;
					end
				end
				slcp_pkg::PH_LEN: begin
					if (rx_byte == 8'd0) begin
						phase_d  = slcp_pkg::PH_HUNT;
						status_d = slcp_pkg::ST_ZERO;
					end else if (rx_byte > slcp_pkg::LEN_LIMIT) begin
						phase_d  = slcp_pkg::PH_HUNT;
						status_d = slcp_pkg::ST_LONG;
					end else begin
						frame_length_d = rx_byte;
						byte_count_d   = 8'd0;
						crc_d          = slcp_pkg::crc8_step(8'd0, rx_byte);
						phase_d        = slcp_pkg::PH_DATA;
					end
				end
				slcp_pkg::PH_DATA: begin
					crc_d        = slcp_pkg::crc8_step(crc_q, rx_byte);
					byte_count_d = count_inc;
					if (byte_count_q == 8'd0) begin
						cmd_d = rx_byte;
					end
					if (count_inc >= frame_length_q) begin
						phase_d = slcp_pkg::PH_CHECK;
					end
				end
				slcp_pkg::PH_CHECK: begin
					phase_d = slcp_pkg::PH_HUNT;
					if (rx_byte != crc_q) begin
						status_d = slcp_pkg::ST_CRC;
					end else begin
						pub_cmd_d = cmd_q;
						pub_len_d = frame_length_q - 8'd1;
						bank_d    = !bank_q;
						status_d  = slcp_pkg::ST_DONE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= slcp_pkg::PH_HUNT;
			frame_length_q <= 8'd0;
			byte_count_q   <= 8'd0;
			crc_q          <= 8'd0;
			bank_q         <= 1'b0;
			pub_cmd_q      <= 8'd0;
			pub_len_q      <= 8'd0;
			valid_s1       <= 1'b0;
		end else begin
			if (accept) begin
				phase_q        <= phase_d;
				frame_length_q <= frame_length_d;
				byte_count_q   <= byte_count_d;
				crc_q          <= crc_d;
				bank_q         <= bank_d;
				pub_cmd_q      <= pub_cmd_d;
				pub_len_q      <= pub_len_d;
				valid_s1       <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// payload registers of the read stage
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd_d;
			status_s1 <= status_d;
			hit_s1    <= req_type && (read_index < pub_len_q);
			cmd_s1    <= pub_cmd_d;
			len_s1    <= pub_len_d;
		end
	end

	// frame store: writes go to the filling bank, reads to the published one
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[{bank_q, byte_count_q}] <= rx_byte;
		end
		if (accept && req_type) begin
			rd_q <= store_mem[{!bank_q, read_index + 8'd1}];
		end
	end

	assign stage.valid  = valid_s1;
	assign stage.status = status_s1;
	assign stage.hit    = hit_s1;
	assign stage.cmd    = cmd_s1;
	assign stage.len    = len_s1;
	assign stage.rdata  = rd_q;

endmodule

FILE: hw/rtl/sync_len_crc8_packet_parser_core.sv
// top level of the sync/length/crc8 byte-stream deframer
`timescale 1ns / 1ps

// channel   | beat fields                          | handshake
// ----------+--------------------------------------+---------------------
// input     | req_type, rx_byte, read_index        | in_valid / in_stall
// output    | status, read_data, frame_cmd,        | out_valid / out_stall
//           | frame_payload_len                    |
// config    | cfg_wdata (sync value)               | cfg_we
//
// one beat per cycle sustained while out_stall is low; each beat passes the
// read stage (parser update and frame store read) and then the output
// register. the store has a single read and a single write port.
// reset returns to sync hunt, bank 0, nothing published, sync value 0xaa.
// out_stall holds the output register; the read stage then holds too and
// in_stall rises only when both are full.

module sync_len_crc8_packet_parser_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       req_type,
	input  logic [7:0] rx_byte,
	input  logic [7:0] read_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] read_data,
	output logic [7:0] frame_cmd,
	output logic [7:0] frame_payload_len
);

	logic             [7:0] sync_q;
	slcp_pkg::stage_t       stage;
	logic                   out_valid_q;
	logic                   advance;
	logic                   accept;

	// read stage empties when the output register is free or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = stage.valid && !advance;
	assign accept   = in_valid && !in_stall;

	// sync value register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= slcp_pkg::SYNC_RESET;
		end else if (cfg_we) begin
			sync_q <= cfg_wdata;
		end
	end

	slcp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.sync_value (sync_q),
		.accept     (accept),
		.advance    (advance),
		.req_type   (req_type),
		.rx_byte    (rx_byte),
		.read_index (read_index),
		.stage      (stage)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= stage.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && stage.valid) begin
			status            <= stage.status;
			// reads past the published length answer zero
			read_data         <= stage.hit ? stage.rdata : 8'd0;
			frame_cmd         <= stage.cmd;
			frame_payload_len <= stage.len;
		end
	end

	assign out_valid = out_valid_q;

endmodule
